FILE: design/vocc_pkg.sv
// Shared types and constants for the voxel octree occupancy store.
// Holds the command and response structs and the sequencer state type.
// No dependencies.
package vocc_pkg;

	localparam int COORD_W = 8;
	localparam int VOXEL_W = 8;
	localparam int TYPE_W  = 3;
	localparam int LEVEL_W = 3;

	// Low bits of a voxel byte hold the block type, occupancy bits sit above
	localparam int OCC_BASE = 3;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_READ  = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [COORD_W-1:0] x_coord;
		logic [COORD_W-1:0] y_coord;
		logic [COORD_W-1:0] z_coord;
		logic [TYPE_W-1:0]  block_type;
		logic [LEVEL_W-1:0] level;
	} vocc_cmd_t;

	typedef struct packed {
		logic [TYPE_W-1:0] read_value;
		logic              status;
	} vocc_rsp_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_UPDATE
	} vocc_state_t;

endpackage

FILE: design/vocc_ram.sv
// Voxel byte memory: one write port, one read port with registered read data.
// Depends on vocc_pkg for the voxel byte width.
module vocc_ram
	import vocc_pkg::*;
#(
	parameter int AW = 12
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [VOXEL_W-1:0] wdata,
	input  logic [AW-1:0]      raddr,
	output logic [VOXEL_W-1:0] rdata
);

	logic [VOXEL_W-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: design/voxel_octree_occupancy_store.sv
// Top level of the voxel octree occupancy store: sequencer, coordinate unit
// and the voxel byte memory. Depends on vocc_pkg and vocc_ram.
//
//   channel   ports                  timing
//   command   start, busy, cmd       taken at an edge with start high, busy low
//   response  done, rsp              one-cycle strobe, no backpressure
//
// Every memory location visited takes a read state and an update state on the
// single memory port pair. A write visits LEVELS+1 locations; a read at a level
// visits one location. An out-of-range command answers in the cycle after it is
// taken, without busy going high.
// After reset the memory is swept to zero, one byte a cycle, with busy high.
// The response side never stalls.
module voxel_octree_occupancy_store
	import vocc_pkg::*;
#(
	parameter int LEVELS = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  vocc_cmd_t cmd,
	output logic      done,
	output vocc_rsp_t rsp
);

	localparam int AW     = 3 * LEVELS;
	localparam int STEP_W = $clog2(LEVELS + 1);

	vocc_state_t state_q, state_d;

	logic [LEVELS-1:0]  cx_q, cy_q, cz_q;
	logic [STEP_W-1:0]  step_q;
	logic               mode_q;
	logic [TYPE_W-1:0]  type_q;
	logic [LEVEL_W-1:0] lvl_q;
	logic [AW-1:0]      clr_addr_q;
	logic               done_q;
	vocc_rsp_t          rsp_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [VOXEL_W-1:0] ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [VOXEL_W-1:0] ram_rdata;

	logic               accept;
	logic               cmd_err;
	logic [LEVELS-1:0]  lvl_mask;
	logic [AW-1:0]      cur_addr;
	logic               last_step;
	logic               clr_last;
	logic [VOXEL_W-1:0] rd_shifted;
	logic [TYPE_W-1:0]  rd_value;

	assign accept = start && (state_q == ST_IDLE);

	assign cmd_err = ((cmd.x_coord >> LEVELS) != '0) ||
			 ((cmd.y_coord >> LEVELS) != '0) ||
			 ((cmd.z_coord >> LEVELS) != '0) ||
			 ((cmd.mode == MODE_READ) && (cmd.level > LEVEL_W'(LEVELS)));

	// Clear the low 'level' bits of each coordinate to get the aligned corner
	assign lvl_mask = {LEVELS{1'b1}} << cmd.level;

	assign cur_addr  = {cx_q, cy_q, cz_q};
	assign last_step = (step_q == STEP_W'(LEVELS));
	assign clr_last  = (clr_addr_q == {AW{1'b1}});

	assign rd_shifted = ram_rdata >> ({1'b0, lvl_q} + 4'd2);
	assign rd_value   = (lvl_q == '0) ? ram_rdata[TYPE_W-1:0]
				      : {{(TYPE_W-1){1'b0}}, rd_shifted[0]};

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept && !cmd_err) state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (mode_q == MODE_READ || last_step) state_d = ST_IDLE;
				else state_d = ST_READ;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_addr;
		ram_wdata = ram_rdata;
		ram_raddr = cur_addr;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
			end
			ST_UPDATE: begin
				if (mode_q == MODE_WRITE) begin
					ram_we = 1'b1;
					if (step_q == '0) begin
						ram_wdata = {ram_rdata[VOXEL_W-1:TYPE_W], type_q};
					end else begin
						// step k marks occupancy of level k: bit k+2
						ram_wdata = ram_rdata | (VOXEL_W'(1 << (OCC_BASE - 1)) << step_q);
					end
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			done_q     <= 1'b0;
			step_q     <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
				ST_IDLE: begin
					if (accept) begin
						step_q <= '0;
						if (cmd_err) begin
							done_q <= 1'b1;
						end
					end
				end
				ST_UPDATE: begin
					if (mode_q == MODE_READ || last_step) begin
						done_q <= 1'b1;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				default: begin
					done_q <= 1'b0;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mode_q <= cmd.mode;
					type_q <= cmd.block_type;
					lvl_q  <= cmd.level;
					if (cmd.mode == MODE_READ) begin
						cx_q <= cmd.x_coord[LEVELS-1:0] & lvl_mask;
						cy_q <= cmd.y_coord[LEVELS-1:0] & lvl_mask;
						cz_q <= cmd.z_coord[LEVELS-1:0] & lvl_mask;
					end else begin
						cx_q <= cmd.x_coord[LEVELS-1:0];
						cy_q <= cmd.y_coord[LEVELS-1:0];
						cz_q <= cmd.z_coord[LEVELS-1:0];
					end
					rsp_q.read_value <= '0;
					rsp_q.status     <= cmd_err ? STATUS_ERR : STATUS_OK;
				end
			end
			ST_UPDATE: begin
				if (mode_q == MODE_READ) begin
					rsp_q.read_value <= rd_value;
				end else if (!last_step) begin
					// Advance to the next coarser corner: drop one more low bit
					cx_q <= cx_q & ~(LEVELS'(1) << step_q);
					cy_q <= cy_q & ~(LEVELS'(1) << step_q);
					cz_q <= cz_q & ~(LEVELS'(1) << step_q);
				end
			end
			default: begin
				rsp_q <= rsp_q;
			end
		endcase
	end

	vocc_ram #(
		.AW(AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
